### hw/rtl/b2b_pkg.sv
package b2b_pkg;

    localparam int ROUNDS      = 12;
    localparam int RND_W       = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int WORD_W      = 64;
    localparam int POS_W       = 4;
    localparam int SLOT_W      = 1;
    localparam int RAM_AW      = POS_W + SLOT_W;
    localparam int RAM_DEPTH   = 1 << RAM_AW;
    localparam int IDX_W       = 3;
    localparam int STEP_W      = 5;
    localparam int SIGMA_ROWS  = 10;
    localparam int RMOD_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_W       = 8;
    localparam int DIGEST_W    = 7;
    localparam int EQ_W        = 32;

    localparam logic [LEN_W-1:0]  MAX_BLOCK   = 8'd128;
    localparam logic [31:0]       PARAM_BASE  = 32'h0101_0000;
    localparam logic [STEP_W-1:0] STEP_DIAG   = 5'd8;
    localparam logic [STEP_W-1:0] STEP_UNDIAG = 5'd17;
    localparam logic [POS_W-1:0]  LAST_POS    = 4'd15;

    localparam logic [WORD_W-1:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [3:0] SIGMA [SIGMA_ROWS][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIGEST   = 2'd0,
        CFG_PERSONAL = 2'd1,
        CFG_EQ_N     = 2'd2,
        CFG_EQ_K     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DIGEST_W-1:0] digest_bytes;
        logic [WORD_W-1:0]   personal_word;
        logic [EQ_W-1:0]     equihash_n;
        logic [EQ_W-1:0]     equihash_k;
    } cfg_t;

    typedef struct packed {
        logic              reload;
        logic              final_blk;
        logic [WORD_W-1:0] counter;
        logic [SLOT_W-1:0] slot;
    } job_t;

    // message word used by a half-G step; diagonal steps sit one place later
    function automatic logic [POS_W-1:0] msg_sel(logic [RMOD_W-1:0] rmod,
                                                 logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] pos;
        pos = (step < STEP_DIAG) ? step : step - 5'd1;
        return SIGMA[rmod][pos[POS_W-1:0]];
    endfunction

endpackage

### hw/rtl/blake2b_block_compressor.sv
// Takes 128-byte blocks as sixteen pushed 64-bit words and returns eight
// chaining words per compressed block. Each push is taken while the job
// queue has room; the front buffers one further block while the back
// compresses. Each compression runs ROUNDS rounds on the single shared G
// datapath, which does half a G function per cycle, with a diagonal and an
// undiagonal shuffle step in each round. Results leave through an
// eight-word buffer, one per pop.
module blake2b_block_compressor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [b2b_pkg::WORD_W-1:0]          msg_word,
    input  logic [b2b_pkg::LEN_W-1:0]           block_len,
    input  logic                                final_block,
    input  logic                                start_chain,
    output logic                                empty,
    input  logic                                pop,
    output logic [b2b_pkg::WORD_W-1:0]          hash_word,
    output logic [b2b_pkg::IDX_W-1:0]           word_index,
    output logic                                last_word,
    input  logic                                cfg_wr_en,
    input  logic [b2b_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [b2b_pkg::WORD_W-1:0]          cfg_wr_data
);

    import b2b_pkg::*;

    cfg_t              cfg_reg;
    logic              q_full;
    logic              q_valid;
    logic              job_push;
    logic              job_pop;
    job_t              job_in;
    job_t              job_head;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [RAM_AW-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.digest_bytes  <= 7'd64;
            cfg_reg.personal_word <= '0;
            cfg_reg.equihash_n    <= '0;
            cfg_reg.equihash_k    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_DIGEST:   cfg_reg.digest_bytes  <= cfg_wr_data[DIGEST_W-1:0];
                CFG_PERSONAL: cfg_reg.personal_word <= cfg_wr_data;
                CFG_EQ_N:     cfg_reg.equihash_n    <= cfg_wr_data[EQ_W-1:0];
                CFG_EQ_K:     cfg_reg.equihash_k    <= cfg_wr_data[EQ_W-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    b2b_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .msg_word    (msg_word),
        .block_len   (block_len),
        .final_block (final_block),
        .start_chain (start_chain),
        .q_full      (q_full),
        .job_push    (job_push),
        .job         (job_in),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata)
    );

    b2b_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_msg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    b2b_jobq u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .pop   (job_pop),
        .dout  (job_head),
        .valid (q_valid),
        .full  (q_full)
    );

    b2b_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job_valid  (q_valid),
        .job        (job_head),
        .job_pop    (job_pop),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .empty      (empty),
        .pop        (pop),
        .hash_word  (hash_word),
        .word_index (word_index),
        .last_word  (last_word)
    );

endmodule

### hw/rtl/b2b_ram.sv
module b2b_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/b2b_jobq.sv
module b2b_jobq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  b2b_pkg::job_t din,
    input  logic          pop,
    output b2b_pkg::job_t dout,
    output logic          valid,
    output logic          full
);

    import b2b_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign dout  = entry_reg[rd_ptr_reg];
    assign valid = (count_reg != 2'd0);
    assign full  = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/b2b_front.sv
module b2b_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [b2b_pkg::WORD_W-1:0]            msg_word,
    input  logic [b2b_pkg::LEN_W-1:0]             block_len,
    input  logic                                  final_block,
    input  logic                                  start_chain,
    input  logic                                  q_full,
    output logic                                  job_push,
    output b2b_pkg::job_t                         job,
    output logic                                  ram_we,
    output logic [b2b_pkg::RAM_AW-1:0]            ram_waddr,
    output logic [b2b_pkg::WORD_W-1:0]            ram_wdata
);

    import b2b_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WORD_W-1:0] cnt_reg, cnt_next;
    logic              reload_reg, reload_next;

    logic              accept;
    logic [POS_W-1:0]  pos_eff;
    logic [WORD_W-1:0] cnt_eff;
    logic [WORD_W-1:0] cnt_sum;
    logic              reload_eff;

    assign full       = q_full;
    assign accept     = push & ~q_full;
    assign pos_eff    = start_chain ? '0 : pos_reg;
    assign cnt_eff    = start_chain ? '0 : cnt_reg;
    assign cnt_sum    = cnt_eff + {{(WORD_W-LEN_W){1'b0}}, block_len};
    assign reload_eff = start_chain | reload_reg;

    assign ram_we    = accept;
    assign ram_waddr = {slot_reg, pos_eff};
    assign ram_wdata = msg_word;

    assign job.reload    = reload_eff;
    assign job.final_blk = final_block;
    assign job.counter   = cnt_sum;
    assign job.slot      = slot_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        slot_next   = slot_reg;
        cnt_next    = cnt_reg;
        reload_next = reload_reg;
        job_push    = 1'b0;
        if (accept)
        begin
            cnt_next    = cnt_eff;
            reload_next = reload_eff;
            if (pos_eff == LAST_POS)
            begin
                pos_next = '0;
                // an oversized block is dropped
                if (block_len <= MAX_BLOCK)
                begin
                    job_push    = 1'b1;
                    cnt_next    = cnt_sum;
                    reload_next = 1'b0;
                    slot_next   = slot_reg + 1'b1;
                end
            end
            else
            begin
                pos_next = pos_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            slot_reg   <= '0;
            cnt_reg    <= '0;
            reload_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            slot_reg   <= slot_next;
            cnt_reg    <= cnt_next;
            reload_reg <= reload_next;
        end
    end

endmodule

### hw/rtl/b2b_back.sv
module b2b_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  b2b_pkg::cfg_t                 cfg,
    input  logic                          job_valid,
    input  b2b_pkg::job_t                 job,
    output logic                          job_pop,
    output logic [b2b_pkg::RAM_AW-1:0]    ram_raddr,
    input  logic [b2b_pkg::WORD_W-1:0]    ram_rdata,
    output logic                          empty,
    input  logic                          pop,
    output logic [b2b_pkg::WORD_W-1:0]    hash_word,
    output logic [b2b_pkg::IDX_W-1:0]     word_index,
    output logic                          last_word
);

    import b2b_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_INIT = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_XFER = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [RND_W-1:0]   round_reg, round_next;
    logic [RMOD_W-1:0]  rmod_reg, rmod_next;
    logic [WORD_W-1:0]  v_reg [4][4];
    logic [WORD_W-1:0]  v_next [4][4];
    logic [WORD_W-1:0]  chain_reg [8];
    logic [WORD_W-1:0]  chain_next [8];
    logic [WORD_W-1:0]  chain_init [8];
    logic [WORD_W-1:0]  chain_src [8];
    logic [WORD_W-1:0]  out_word_reg [8];
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_busy_reg;
    logic               out_load;

    logic [STEP_W-1:0]  nstep;
    logic [RMOD_W-1:0]  nrmod;
    logic               phase;
    logic [WORD_W-1:0]  ga, gb, gc, gd;

    // row k column j holds work word 4k+j; G always works on column 0
    always_comb
    begin
        chain_init[0] = IV[0] ^ {32'd0, PARAM_BASE | {25'd0, cfg.digest_bytes}};
        for (int i = 1; i < 6; i++)
        begin
            chain_init[i] = IV[i];
        end
        chain_init[6] = IV[6] ^ cfg.personal_word;
        chain_init[7] = IV[7] ^ {cfg.equihash_k, cfg.equihash_n};
        for (int i = 0; i < 8; i++)
        begin
            chain_src[i] = job.reload ? chain_init[i] : chain_reg[i];
        end
    end

    // half of the G function per cycle
    always_comb
    begin
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] dx;
        logic [WORD_W-1:0] bx;
        phase = (step_reg < STEP_DIAG) ? step_reg[0] : ~step_reg[0];
        ga = v_reg[0][0] + v_reg[1][0] + ram_rdata;
        x  = v_reg[3][0] ^ ga;
        dx = phase ? {x[15:0], x[63:16]} : {x[31:0], x[63:32]};
        gd = dx;
        gc = v_reg[2][0] + gd;
        bx = v_reg[1][0] ^ gc;
        gb = phase ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
    end

    always_comb
    begin
        nstep = (step_reg == STEP_UNDIAG) ? '0 : step_reg + 1'b1;
        nrmod = rmod_reg;
        if (step_reg == STEP_UNDIAG)
        begin
            nrmod = (rmod_reg == RMOD_W'(SIGMA_ROWS - 1)) ? '0 : rmod_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        round_next = round_reg;
        rmod_next  = rmod_reg;
        v_next     = v_reg;
        chain_next = chain_reg;
        job_pop    = 1'b0;
        out_load   = 1'b0;
        ram_raddr  = {job.slot, msg_sel(nrmod, nstep)};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_INIT;
                    step_next  = '0;
                    round_next = '0;
                    rmod_next  = '0;
                end
            end
            ST_INIT:
            begin
                ram_raddr = {job.slot, msg_sel('0, '0)};
                for (int j = 0; j < 4; j++)
                begin
                    v_next[0][j] = chain_src[j];
                    v_next[1][j] = chain_src[4 + j];
                    v_next[2][j] = IV[j];
                    v_next[3][j] = IV[4 + j];
                end
                v_next[3][0] = IV[4] ^ job.counter;
                v_next[3][2] = IV[6] ^ {WORD_W{job.final_blk}};
                chain_next   = chain_src;
                state_next   = ST_RUN;
            end
            ST_RUN:
            begin
                if (step_reg == STEP_DIAG)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        v_next[1][j] = v_reg[1][(j + 1) % 4];
                        v_next[2][j] = v_reg[2][(j + 2) % 4];
                        v_next[3][j] = v_reg[3][(j + 3) % 4];
                    end
                end
                else if (step_reg == STEP_UNDIAG)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        v_next[1][j] = v_reg[1][(j + 3) % 4];
                        v_next[2][j] = v_reg[2][(j + 2) % 4];
                        v_next[3][j] = v_reg[3][(j + 1) % 4];
                    end
                end
                else if (!phase)
                begin
                    v_next[0][0] = ga;
                    v_next[1][0] = gb;
                    v_next[2][0] = gc;
                    v_next[3][0] = gd;
                end
                else
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            v_next[k][j] = v_reg[k][j + 1];
                        end
                    end
                    v_next[0][3] = ga;
                    v_next[1][3] = gb;
                    v_next[2][3] = gc;
                    v_next[3][3] = gd;
                end
                step_next = nstep;
                rmod_next = nrmod;
                if (step_reg == STEP_UNDIAG)
                begin
                    round_next = round_reg + 1'b1;
                    if (round_reg == RND_W'(ROUNDS - 1))
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] ^ v_reg[i / 4][i % 4]
                                  ^ v_reg[2 + i / 4][i % 4];
                end
                state_next = ST_XFER;
            end
            ST_XFER:
            begin
                if (!out_busy_reg)
                begin
                    out_load   = 1'b1;
                    job_pop    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign empty      = ~out_busy_reg;
    assign hash_word  = out_word_reg[out_idx_reg];
    assign word_index = out_idx_reg;
    assign last_word  = (out_idx_reg == IDX_W'(7));

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        if (out_load)
        begin
            out_word_reg <= chain_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            round_reg    <= '0;
            rmod_reg     <= '0;
            out_idx_reg  <= '0;
            out_busy_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            round_reg <= round_next;
            rmod_reg  <= rmod_next;
            chain_reg <= chain_next;
            if (out_load)
            begin
                out_idx_reg  <= '0;
                out_busy_reg <= 1'b1;
            end
            else if (pop && out_busy_reg)
            begin
                out_idx_reg <= out_idx_reg + 1'b1;
                if (out_idx_reg == IDX_W'(7))
                begin
                    out_busy_reg <= 1'b0;
                end
            end
        end
    end

    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("job popped from empty queue");

    a_load_from_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_busy_reg) |-> $past(state_reg) == ST_XFER)
        else $error("result buffer loaded outside transfer");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= STEP_UNDIAG))
        else $error("round step out of range");

endmodule
